// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the estimator core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// File: rtl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Types, register codes and helpers of the retransmission timeout estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rte_pkg;

	localparam int RTO_W  = 16;
	localparam int MS_W   = 32;
	localparam int SEQ_W  = 16;
	localparam int SH_W   = 3;
	localparam int IDX_W  = 3;
	localparam int WIDE_W = MS_W + 3;

	localparam logic [RTO_W-1:0] RTO_INITIAL_RST = 16'd3000;
	localparam logic [RTO_W-1:0] RTO_MIN_RST     = 16'd1000;
	localparam logic [RTO_W-1:0] RTO_MAX_RST     = 16'd60000;
	localparam logic [SH_W-1:0]  ALPHA_RST       = 3'd3;
	localparam logic [SH_W-1:0]  BETA_RST        = 3'd2;
	localparam logic [RTO_W-1:0] FLOOR_RST       = 16'd50;

	typedef enum logic [1:0] {
		FUNC_SEND    = 2'd0,
		FUNC_ACK     = 2'd1,
		FUNC_BACKOFF = 2'd2,
		FUNC_NOP     = 2'd3
	} rte_func_t;

	typedef enum logic [IDX_W-1:0] {
		REG_RTO_INITIAL  = 3'd0,
		REG_RTO_MIN      = 3'd1,
		REG_RTO_MAX      = 3'd2,
		REG_ALPHA_SHIFT  = 3'd3,
		REG_BETA_SHIFT   = 3'd4,
		REG_RTTVAR_FLOOR = 3'd5
	} rte_reg_t;

	// initial timeout goes straight into the estimator state
	typedef struct packed {
		logic [RTO_W-1:0] rto_min;
		logic [RTO_W-1:0] rto_max;
		logic [SH_W-1:0]  alpha_shift;
		logic [SH_W-1:0]  beta_shift;
		logic [RTO_W-1:0] rttvar_floor;
	} rte_cfg_t;

	typedef struct packed {
		logic [RTO_W-1:0] rto;
		logic [MS_W-1:0]  srtt;
		logic [MS_W-1:0]  rttvar;
		logic [MS_W-1:0]  last_rtt;
		logic             measuring;
		logic             have_sample;
		logic [SEQ_W-1:0] timed_seq;
		logic [MS_W-1:0]  sample_start;
	} rte_state_t;

	// min first, max last
	function automatic logic [RTO_W-1:0] clamp_rto(input logic [WIDE_W-1:0] v,
			input logic [RTO_W-1:0] lo, input logic [RTO_W-1:0] hi);
		logic [WIDE_W-1:0] t;
		t = (v < WIDE_W'(lo)) ? WIDE_W'(lo) : v;
		return (t > WIDE_W'(hi)) ? hi : t[RTO_W-1:0];
	endfunction

	// gain step: x - (x >> sh) + (y >> sh), saturating
	function automatic logic [MS_W-1:0] ewma_step(input logic [MS_W-1:0] x,
			input logic [MS_W-1:0] y, input logic [SH_W-1:0] sh);
		logic [MS_W:0] s;
		s = {1'b0, x - (x >> sh)} + {1'b0, y >> sh};
		return s[MS_W] ? {MS_W{1'b1}} : s[MS_W-1:0];
	endfunction

endpackage

// File: rtl/rte_cfg_regs.sv
// ----------------------------------------------------------------------------
// rte_cfg_regs
// Configuration register file of the timeout estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rte_cfg_regs import rte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [RTO_W-1:0] cfg_data,
	output rte_cfg_t         cfg,
	output logic             init_load
);

	rte_cfg_t cfg_q;
	logic     wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;
	assign init_load = wr && (cfg_index == REG_RTO_INITIAL);
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rto_min      <= RTO_MIN_RST;
			cfg_q.rto_max      <= RTO_MAX_RST;
			cfg_q.alpha_shift  <= ALPHA_RST;
			cfg_q.beta_shift   <= BETA_RST;
			cfg_q.rttvar_floor <= FLOOR_RST;
		end else if (wr) begin
			unique case (cfg_index)
				REG_RTO_MIN:      cfg_q.rto_min      <= cfg_data;
				REG_RTO_MAX:      cfg_q.rto_max      <= cfg_data;
				REG_ALPHA_SHIFT:  cfg_q.alpha_shift  <= cfg_data[SH_W-1:0];
				REG_BETA_SHIFT:   cfg_q.beta_shift   <= cfg_data[SH_W-1:0];
				REG_RTTVAR_FLOOR: cfg_q.rttvar_floor <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/rte_update.sv
// ----------------------------------------------------------------------------
// rte_update
// Next-state logic: sample timing, smoothing, variance floor, clamp, backoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rte_update import rte_pkg::*; (
	input  rte_cfg_t         cfg,
	input  rte_state_t       st,
	input  logic [1:0]       func,
	input  logic [SEQ_W-1:0] seq_num,
	input  logic [MS_W-1:0]  now_ms,
	input  logic             first_send,
	output rte_state_t       nst,
	output logic [RTO_W-1:0] delta
);

	logic [MS_W-1:0]   elapsed;
	logic [MS_W-1:0]   rtt;
	logic [MS_W-1:0]   diff;
	logic [MS_W-1:0]   srtt_new;
	logic [MS_W-1:0]   var_pre;
	logic [MS_W-1:0]   var_new;
	logic [WIDE_W-1:0] rto_raw;
	logic [RTO_W-1:0]  rto_upd;
	logic [RTO_W-1:0]  rto_bo;
	logic              stale;

	assign elapsed = now_ms - st.sample_start;
	assign rtt     = (elapsed == '0) ? MS_W'(1) : elapsed;
	assign diff    = (st.srtt > rtt) ? st.srtt - rtt : rtt - st.srtt;
	assign stale   = elapsed > MS_W'(cfg.rto_max);

	assign srtt_new = st.have_sample ? ewma_step(st.srtt, rtt, cfg.alpha_shift) : rtt;
	assign var_pre  = st.have_sample ? ewma_step(st.rttvar, diff, cfg.beta_shift)
		: (rtt >> 1);
	assign var_new  = (var_pre < MS_W'(cfg.rttvar_floor)) ? MS_W'(cfg.rttvar_floor)
		: var_pre;
	assign rto_raw  = WIDE_W'(srtt_new) + {1'b0, var_new, 2'b00};
	assign rto_upd  = clamp_rto(rto_raw, cfg.rto_min, cfg.rto_max);
	assign rto_bo   = clamp_rto(WIDE_W'({st.rto, 1'b0}), cfg.rto_min, cfg.rto_max);

	always_comb begin
		nst   = st;
		delta = '0;
		case (rte_func_t'(func))
			FUNC_SEND: begin
				if (st.measuring) begin
					if (stale) begin
						nst.measuring = 1'b0;
					end
				end else if (first_send) begin
					nst.timed_seq    = seq_num;
					nst.sample_start = now_ms;
					nst.measuring    = 1'b1;
				end
			end
			FUNC_ACK: begin
				if (st.measuring) begin
					if (seq_num == st.timed_seq) begin
						nst.last_rtt    = rtt;
						nst.srtt        = srtt_new;
						nst.rttvar      = var_new;
						nst.have_sample = 1'b1;
						nst.rto         = rto_upd;
					end
					nst.measuring = 1'b0;
				end
			end
			FUNC_BACKOFF: begin
				nst.rto = rto_bo;
				delta   = (rto_bo > st.rto) ? rto_bo - st.rto : '0;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/retransmission_timeout_estimator_core.sv
// ----------------------------------------------------------------------------
// retransmission_timeout_estimator_core
// Round-trip estimator and retransmission timeout with backoff.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while in_stall is low. It passes the
// input register, then a single pass of the update logic rewrites the estimator
// state registers that offer its result, for every item; an output register
// with a stall-driven hold lets a new item enter while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module retransmission_timeout_estimator_core import rte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [RTO_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       func,
	input  logic [SEQ_W-1:0] seq_num,
	input  logic [MS_W-1:0]  now_ms,
	input  logic             first_send,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [RTO_W-1:0] rto_ms,
	output logic [MS_W-1:0]  srtt_ms,
	output logic [MS_W-1:0]  rttvar_ms,
	output logic [MS_W-1:0]  last_rtt_ms,
	output logic             sample_pending,
	output logic [RTO_W-1:0] backoff_delta_ms
);

	rte_cfg_t         cfg;
	logic             init_load;
	rte_state_t       state_q;
	rte_state_t       nst;
	logic [RTO_W-1:0] delta;
	logic [RTO_W-1:0] delta_q;
	logic             out_valid_q;
	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [SEQ_W-1:0] seq_s1;
	logic [MS_W-1:0]  now_s1;
	logic             first_s1;
	logic             adv;

	rte_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.init_load (init_load)
	);

	rte_update u_upd (
		.cfg        (cfg),
		.st         (state_q),
		.func       (func_s1),
		.seq_num    (seq_s1),
		.now_ms     (now_s1),
		.first_send (first_s1),
		.nst        (nst),
		.delta      (delta)
	);

	assign adv      = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall = valid_s1 & out_valid_q & out_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			seq_s1   <= seq_num;
			now_s1   <= now_ms;
			first_s1 <= first_send;
		end
	end

	// estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rto          <= RTO_INITIAL_RST;
			state_q.srtt         <= '0;
			state_q.rttvar       <= '0;
			state_q.last_rtt     <= '0;
			state_q.measuring    <= 1'b0;
			state_q.have_sample  <= 1'b0;
			state_q.timed_seq    <= '0;
			state_q.sample_start <= '0;
		end else if (init_load) begin
			state_q.rto <= cfg_data;
		end else if (adv) begin
			state_q <= nst;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			delta_q <= delta;
		end
	end

	assign out_valid        = out_valid_q;
	assign rto_ms           = state_q.rto;
	assign srtt_ms          = state_q.srtt;
	assign rttvar_ms        = state_q.rttvar;
	assign last_rtt_ms      = state_q.last_rtt;
	assign sample_pending   = state_q.measuring;
	assign backoff_delta_ms = delta_q;

	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_valid_q && out_stall && !cfg_valid, $stable(state_q) && $stable(delta_q), "state moved while result stalled")
	`ASSERT_NEXT(a_backoff_keeps_sample, clk, arst_n, adv && (func_s1 == FUNC_BACKOFF), $stable(state_q.measuring) && $stable(state_q.srtt), "backoff touched sample state")
	`ASSERT_CLK(a_have_sample_sticky, clk, arst_n, !$fell(state_q.have_sample), "have_sample cleared")
	`ASSERT_NEXT(a_stall_only_when_full, clk, arst_n, in_stall, out_valid_q && valid_s1, "input stalled with empty pipeline")

endmodule

// File: test/tb_retransmission_timeout_estimator_core.sv
// ----------------------------------------------------------------------------
// tb_retransmission_timeout_estimator_core
// Self-checking bench for the retransmission timeout estimator. Send, ack,
// backoff and unused events go in under random valid gaps and output stalls.
// Every result is compared with an in-bench predictor of the clamped timeout,
// smoothed RTT, variance, last RTT, sample state and backoff delta. Register
// settings change between phases, with the clamp, shift and floor extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_retransmission_timeout_estimator_core;
	import rte_pkg::*;

	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_EVENTS = 175;

	typedef struct packed {
		logic [RTO_W-1:0] rto;
		logic [MS_W-1:0]  srtt;
		logic [MS_W-1:0]  rttvar;
		logic [MS_W-1:0]  last_rtt;
		logic             pending;
		logic [RTO_W-1:0] delta;
	} rto_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [RTO_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [1:0]       func = '0;
	logic [SEQ_W-1:0] seq_num = '0;
	logic [MS_W-1:0]  now_ms = '0;
	logic             first_send = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [RTO_W-1:0] rto_ms;
	logic [MS_W-1:0]  srtt_ms;
	logic [MS_W-1:0]  rttvar_ms;
	logic [MS_W-1:0]  last_rtt_ms;
	logic             sample_pending;
	logic [RTO_W-1:0] backoff_delta_ms;

	// predictor registers and state
	logic [RTO_W-1:0] cfg_min, cfg_max, cfg_floor;
	logic [SH_W-1:0]  cfg_alpha, cfg_beta;
	logic [RTO_W-1:0] cur_rto;
	logic [MS_W-1:0]  srtt, rttvar, last_rtt, timing_start;
	logic             timing, have_estimate;
	logic [SEQ_W-1:0] timed_seq;

	rto_result_t expected_estimates[$];
	rto_result_t want, got;
	int          err_count = 0;
	int          events_sent = 0;
	int          items_checked = 0;
	logic [MS_W-1:0] clock_ms = '0;

	bit calm = 1'b0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	retransmission_timeout_estimator_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .seq_num(seq_num), .now_ms(now_ms), .first_send(first_send),
		.out_valid(out_valid), .out_stall(out_stall),
		.rto_ms(rto_ms), .srtt_ms(srtt_ms), .rttvar_ms(rttvar_ms),
		.last_rtt_ms(last_rtt_ms), .sample_pending(sample_pending),
		.backoff_delta_ms(backoff_delta_ms)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [MS_W-1:0] smooth(input logic [MS_W-1:0] est,
			input logic [MS_W-1:0] sample, input logic [SH_W-1:0] sh);
		logic [MS_W:0] acc;
		acc = (MS_W+1)'(est) - (MS_W+1)'(est >> sh) + (MS_W+1)'(sample >> sh);
		if (acc > (MS_W+1)'(32'hFFFF_FFFF))
			acc = (MS_W+1)'(32'hFFFF_FFFF);
		return acc[MS_W-1:0];
	endfunction

	function automatic logic [RTO_W-1:0] bound_timeout(input logic [WIDE_W-1:0] v);
		if (v < WIDE_W'(cfg_min))
			v = WIDE_W'(cfg_min);
		if (v > WIDE_W'(cfg_max))
			v = WIDE_W'(cfg_max);
		return v[RTO_W-1:0];
	endfunction

	function automatic rto_result_t advance_estimator(input rte_func_t f,
			input logic [SEQ_W-1:0] seq, input logic [MS_W-1:0] now, input logic first);
		logic [MS_W-1:0]  elapsed, r, diff;
		logic [RTO_W-1:0] prior;
		rto_result_t      res;
		elapsed = now - timing_start;
		res.delta = '0;
		case (f)
			FUNC_SEND: begin
				if (timing) begin
					if (elapsed > MS_W'(cfg_max))
						timing = 1'b0;
				end else if (first) begin
					timed_seq = seq;
					timing_start = now;
					timing = 1'b1;
				end
			end
			FUNC_ACK: begin
				if (timing) begin
					if (seq == timed_seq) begin
						r = (elapsed == 0) ? 32'd1 : elapsed;
						last_rtt = r;
						if (have_estimate) begin
							diff = (srtt > r) ? srtt - r : r - srtt;
							rttvar = smooth(rttvar, diff, cfg_beta);
							srtt = smooth(srtt, r, cfg_alpha);
						end else begin
							srtt = r;
							rttvar = r >> 1;
							have_estimate = 1'b1;
						end
						if (rttvar < MS_W'(cfg_floor))
							rttvar = MS_W'(cfg_floor);
						cur_rto = bound_timeout(WIDE_W'(srtt) + (WIDE_W'(rttvar) << 2));
					end
					timing = 1'b0;
				end
			end
			FUNC_BACKOFF: begin
				prior = cur_rto;
				cur_rto = bound_timeout(WIDE_W'(prior) << 1);
				res.delta = (cur_rto > prior) ? cur_rto - prior : '0;
			end
			default: ;
		endcase
		res.rto = cur_rto;
		res.srtt = srtt;
		res.rttvar = rttvar;
		res.last_rtt = last_rtt;
		res.pending = timing;
		return res;
	endfunction

	// receiver: random stalls, calm stretches and long hold-offs
	always @(negedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 21);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = '{rto_ms, srtt_ms, rttvar_ms, last_rtt_ms, sample_pending, backoff_delta_ms};
			if (expected_estimates.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: rto=%0d srtt=%0d var=%0d", got.rto, got.srtt,
						got.rttvar);
			end else begin
				want = expected_estimates.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= 10)
						$display({"mismatch at result %0d: exp rto=%0d srtt=%0d var=%0d last=%0d ",
							"pend=%0d delta=%0d, got rto=%0d srtt=%0d var=%0d last=%0d ",
							"pend=%0d delta=%0d"}, items_checked,
							want.rto, want.srtt, want.rttvar, want.last_rtt, want.pending,
							want.delta, got.rto, got.srtt, got.rttvar, got.last_rtt,
							got.pending, got.delta);
				end
			end
			items_checked++;
		end
	end

	task automatic send_item(input rte_func_t f, input logic [SEQ_W-1:0] seq,
			input logic [MS_W-1:0] now, input logic first);
		if (!calm && $urandom_range(0, 99) < 21) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		seq_num = seq;
		now_ms = now;
		first_send = first;
		do @(posedge clk); while (in_stall);
		expected_estimates.push_back(advance_estimator(f, seq, now, first));
		if (f != FUNC_NOP)
			events_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid = 1'b0;
		while (expected_estimates.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input rte_reg_t idx, input logic [RTO_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RTO_INITIAL:  cur_rto = val;
			REG_RTO_MIN:      cfg_min = val;
			REG_RTO_MAX:      cfg_max = val;
			REG_ALPHA_SHIFT:  cfg_alpha = val[SH_W-1:0];
			REG_BETA_SHIFT:   cfg_beta = val[SH_W-1:0];
			REG_RTTVAR_FLOOR: cfg_floor = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one timed packet: first send, up to two more sends, its ack, at times a backoff
	task automatic sample_exchange();
		logic [SEQ_W-1:0] s;
		logic [MS_W-1:0]  start, rtt;
		int               extra;
		s = SEQ_W'($urandom);
		clock_ms += $urandom_range(0, 50);
		start = clock_ms;
		send_item(FUNC_SEND, s, start, 1'b1);
		extra = $urandom_range(0, 2);
		repeat (extra) begin
			clock_ms += $urandom_range(0, 40);
			send_item(FUNC_SEND, SEQ_W'($urandom), clock_ms, 1'($urandom_range(0, 1)));
		end
		case ($urandom_range(0, 9))
			0: rtt = 0;
			1: rtt = $urandom;
			2: rtt = $urandom_range(30000, 70000);
			default: rtt = $urandom_range(1, 4000);
		endcase
		send_item(FUNC_ACK, ($urandom_range(0, 19) == 0) ? s ^ SEQ_W'($urandom_range(1, 65535)) : s,
			start + rtt, 1'($urandom_range(0, 1)));
		clock_ms = start + rtt;
		if ($urandom_range(0, 99) < 15)
			send_item(FUNC_BACKOFF, SEQ_W'($urandom), clock_ms, 1'($urandom_range(0, 1)));
	endtask

	task automatic noise_item();
		send_item(rte_func_t'(2'($urandom_range(0, 3))), SEQ_W'($urandom), $urandom,
			1'($urandom_range(0, 1)));
	endtask

	function automatic logic [RTO_W-1:0] pick_value(input int lo, input int hi, input int spread);
		case ($urandom_range(0, 3))
			0: return RTO_W'(lo);
			1: return RTO_W'(hi);
			default: return RTO_W'($urandom_range(lo, spread));
		endcase
	endfunction

	task automatic test_directed_events();
		send_item(FUNC_NOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_item(FUNC_ACK, 16'h0000, 32'h0, 1'b0);
		send_item(FUNC_SEND, 16'h0001, 32'd10, 1'b0);
		send_item(FUNC_SEND, 16'h1234, 32'd100, 1'b1);
		send_item(FUNC_SEND, 16'h5555, 32'd200, 1'b1);
		send_item(FUNC_ACK, 16'h1235, 32'd300, 1'b1);
		send_item(FUNC_SEND, 16'hABCD, 32'd1000, 1'b1);
		send_item(FUNC_ACK, 16'hABCD, 32'd1000, 1'b0);
		send_item(FUNC_SEND, 16'h0007, 32'hFFFF_FF00, 1'b1);
		send_item(FUNC_ACK, 16'h0007, 32'h0000_0100, 1'b1);
		send_item(FUNC_SEND, 16'h0008, 32'd5000, 1'b1);
		send_item(FUNC_SEND, 16'h0009, 32'd65000, 1'b0);
		send_item(FUNC_SEND, 16'h0009, 32'd65001, 1'b1);
		send_item(FUNC_ACK, 16'h0008, 32'd65002, 1'b0);
		send_item(FUNC_SEND, 16'hFFFF, 32'h0, 1'b1);
		send_item(FUNC_ACK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		repeat (5)
			send_item(FUNC_BACKOFF, 16'h0, 32'h0, 1'b0);
		send_item(FUNC_NOP, 16'h0, 32'h0, 1'b0);
		wait_drain();
	endtask

	task automatic test_register_extremes();
		// min above max: max wins
		write_register(REG_RTO_MIN, 16'd5000);
		write_register(REG_RTO_MAX, 16'd2000);
		write_register(REG_RTO_INITIAL, 16'd1);
		send_item(FUNC_BACKOFF, 16'h0, clock_ms, 1'b0);
		send_item(FUNC_SEND, 16'h0042, clock_ms, 1'b1);
		send_item(FUNC_ACK, 16'h0042, clock_ms + 700, 1'b1);
		clock_ms += 700;
		wait_drain();
		// zero shifts and no floor
		write_register(REG_RTO_MIN, 16'd1);
		write_register(REG_RTO_MAX, 16'd65535);
		write_register(REG_ALPHA_SHIFT, 16'd0);
		write_register(REG_BETA_SHIFT, 16'd0);
		write_register(REG_RTTVAR_FLOOR, 16'd0);
		repeat (3)
			sample_exchange();
		wait_drain();
		// slowest gains, top floor and initial timeout
		write_register(REG_ALPHA_SHIFT, 16'd7);
		write_register(REG_BETA_SHIFT, 16'd7);
		write_register(REG_RTTVAR_FLOOR, 16'd65535);
		write_register(REG_RTO_INITIAL, 16'd65535);
		send_item(FUNC_BACKOFF, 16'h0, clock_ms, 1'b1);
		repeat (3)
			sample_exchange();
		wait_drain();
	endtask

	task automatic test_output_holdoff();
		calm = 1'b1;
		hold_req++;
		repeat (20)
			sample_exchange();
		wait_drain();
		calm = 1'b0;
	endtask

	task automatic test_random_traffic();
		int start;
		for (int phase = 0; phase < 8; phase++) begin
			wait_drain();
			write_register(REG_RTO_INITIAL, pick_value(1, 65535, 8000));
			write_register(REG_RTO_MIN, pick_value(1, 65535, 3000));
			write_register(REG_RTO_MAX, pick_value(1, 65535, 65535));
			write_register(REG_ALPHA_SHIFT, RTO_W'($urandom_range(0, 7)));
			write_register(REG_BETA_SHIFT, RTO_W'($urandom_range(0, 7)));
			write_register(REG_RTTVAR_FLOOR, pick_value(0, 65535, 500));
			calm = (phase == 2);
			start = events_sent;
			while (events_sent - start < PHASE_EVENTS) begin
				if ($urandom_range(0, 99) < 75)
					sample_exchange();
				else
					noise_item();
			end
		end
		wait_drain();
		calm = 1'b0;
	endtask

	initial begin
		cfg_min = RTO_MIN_RST;
		cfg_max = RTO_MAX_RST;
		cfg_alpha = ALPHA_RST;
		cfg_beta = BETA_RST;
		cfg_floor = FLOOR_RST;
		cur_rto = RTO_INITIAL_RST;
		srtt = '0;
		rttvar = '0;
		last_rtt = '0;
		timing_start = '0;
		timing = 1'b0;
		have_estimate = 1'b0;
		timed_seq = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_events();
		test_register_extremes();
		test_output_holdoff();
		test_random_traffic();

		wait_drain();
		repeat (4) @(posedge clk);
		if (expected_estimates.size() != 0) begin
			err_count += expected_estimates.size();
			$display("%0d results never arrived", expected_estimates.size());
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rte_pkg.sv
rtl/rte_cfg_regs.sv
rtl/rte_update.sv
rtl/retransmission_timeout_estimator_core.sv
test/tb_retransmission_timeout_estimator_core.sv
